### hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        action_t                  action;
        logic signed [DATA_W-1:0] value;
    } dq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        status_t                  status;
        logic [CNT_W-1:0]         fill_count;
    } dq_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic do_push;
        logic do_pop;
        logic load_direct;
        logic load_mem;
    } dq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic refused;
    } dq_stat_t;

endpackage

### hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes one request, runs it through the datapath, holds the
// result valid flag.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t  cmd
);

    dq_pkg::ctrl_state_t state_reg;
    dq_pkg::ctrl_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                // the result slot must be free by the time this request lands
                in_ready = !out_valid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC:
            begin
                if (stat.refused)
                begin
                    cmd.load_direct = 1'b1;
                    state_next      = dq_pkg::ST_IDLE;
                end
                else if (!stat.is_pop)
                begin
                    cmd.do_push     = 1'b1;
                    cmd.load_direct = 1'b1;
                    state_next      = dq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.do_pop = 1'b1;
                    state_next = dq_pkg::ST_READ;
                end
            end
            dq_pkg::ST_READ:
            begin
                cmd.load_mem = 1'b1;
                state_next   = dq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_direct || cmd.load_mem)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Slot memory, head/tail pointers, item count and the result register.
// ----------------------------------------------------------------------------
module dq_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  dq_pkg::dq_in_t   in_data,
    input  dq_pkg::dq_cmd_t  cmd,
    output dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_out_t  out_data
);

    localparam logic [dq_pkg::IDX_W-1:0] LAST_IDX = dq_pkg::IDX_W'(dq_pkg::DEPTH - 1);
    localparam logic [dq_pkg::CNT_W-1:0] FULL_CNT = dq_pkg::CNT_W'(dq_pkg::DEPTH);

    logic signed [dq_pkg::DATA_W-1:0] mem [dq_pkg::DEPTH];
    logic signed [dq_pkg::DATA_W-1:0] rd_data_reg;

    dq_pkg::dq_in_t             req_reg;
    dq_pkg::dq_out_t            out_reg;
    logic [dq_pkg::IDX_W-1:0]   head_reg;
    logic [dq_pkg::IDX_W-1:0]   head_next;
    logic [dq_pkg::IDX_W-1:0]   tail_reg;
    logic [dq_pkg::IDX_W-1:0]   tail_next;
    logic [dq_pkg::CNT_W-1:0]   count_reg;
    logic [dq_pkg::CNT_W-1:0]   count_next;

    logic [dq_pkg::IDX_W-1:0]   head_inc;
    logic [dq_pkg::IDX_W-1:0]   head_dec;
    logic [dq_pkg::IDX_W-1:0]   tail_inc;
    logic [dq_pkg::IDX_W-1:0]   tail_dec;
    logic [dq_pkg::IDX_W-1:0]   wr_addr;
    logic [dq_pkg::IDX_W-1:0]   rd_addr;
    logic                       at_front;
    logic                       is_pop;
    logic                       full;
    logic                       empty;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;

    assign is_pop   = (req_reg.action == dq_pkg::ACT_POP_FRONT) ||
                      (req_reg.action == dq_pkg::ACT_POP_BACK);
    assign at_front = (req_reg.action == dq_pkg::ACT_PUSH_FRONT) ||
                      (req_reg.action == dq_pkg::ACT_POP_FRONT);
    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);

    assign stat.is_pop  = is_pop;
    assign stat.refused = is_pop ? empty : full;

    // front push writes below head; back pop reads just below tail
    assign wr_addr = at_front ? head_dec : tail_reg;
    assign rd_addr = at_front ? head_reg : tail_dec;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.do_push)
        begin
            count_next = count_reg + 1'b1;
            if (at_front)
                head_next = head_dec;
            else
                tail_next = tail_inc;
        end
        else if (cmd.do_pop)
        begin
            count_next = count_reg - 1'b1;
            if (at_front)
                head_next = head_inc;
            else
                tail_next = tail_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_push)
            mem[wr_addr] <= req_reg.value;
        if (cmd.do_pop)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_data;
        if (cmd.load_direct)
        begin
            out_reg.popped_value <= '0;
            out_reg.fill_count   <= count_next;
            if (!stat.refused)
                out_reg.status <= dq_pkg::STATUS_OK;
            else if (is_pop)
                out_reg.status <= dq_pkg::STATUS_EMPTY;
            else
                out_reg.status <= dq_pkg::STATUS_FULL;
        end
        else if (cmd.load_mem)
        begin
            out_reg.popped_value <= rd_data_reg;
            out_reg.fill_count   <= count_reg;
            out_reg.status       <= dq_pkg::STATUS_OK;
        end
    end

    assign out_data = out_reg;

endmodule

### hdl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit items on a circular buffer.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_data  (action, value)
//  out     | out_valid / out_ready| out_data (popped_value, status, fill_count)
//
//  Pushes and refused requests pass through the idle and execute states; successful
//  pops add a read state, set by the registered read port of the slot memory.
//  A new request is taken once the previous one has been run through and its
//  result has left the output register or is being taken in that cycle.
//  Reset clears pointers and count at once; slot contents are not cleared.
//  A stalled output blocks every new request until its result is taken.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dq_pkg::dq_in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output dq_pkg::dq_out_t out_data
);

    dq_pkg::dq_cmd_t  cmd;
    dq_pkg::dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule
